@@ rtl/vfcm_pkg.sv @@
// Shared types, constants and helpers for the voxel face cull mesher.
`timescale 1ns / 1ps

package vfcm_pkg;

	// Defaults for the top-level parameters
	localparam int CUBE_EDGE_DEF = 16;
	localparam int KIND_BITS_DEF = 8;

	// Field widths
	localparam int OP_W     = 2;
	localparam int POS_W    = 4;
	localparam int IN_KIND_W = 8;
	localparam int PROBE_W  = POS_W + 1;
	localparam int FACES    = 6;
	localparam int FACE_CNT_W = 3;
	localparam int OFFSET_W = 17;
	localparam int COUNT_W  = 13;
	localparam int SUM_W    = 16;

	localparam int VERTS_PER_FACE = 4;
	localparam int SOLID_ID       = 1;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// Probe sequence of a mesh query: center, then the six neighbors
	localparam int NUM_PROBES = 7;
	localparam int PROBE_CNT_W = 3;
	localparam logic [PROBE_CNT_W-1:0] PROBE_CTR = 3'd0;
	localparam logic [PROBE_CNT_W-1:0] PROBE_YP  = 3'd1;
	localparam logic [PROBE_CNT_W-1:0] PROBE_YN  = 3'd2;
	localparam logic [PROBE_CNT_W-1:0] PROBE_ZP  = 3'd3;
	localparam logic [PROBE_CNT_W-1:0] PROBE_ZN  = 3'd4;
	localparam logic [PROBE_CNT_W-1:0] PROBE_XP  = 3'd5;
	localparam logic [PROBE_CNT_W-1:0] PROBE_XN  = 3'd6;
	localparam logic [PROBE_CNT_W-1:0] PROBE_DONE = 3'd7;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_MESH  = 2'd1,
		OP_START = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MESH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]      operation;
		logic [POS_W-1:0]     pos_x;
		logic [POS_W-1:0]     pos_y;
		logic [POS_W-1:0]     pos_z;
		logic [IN_KIND_W-1:0] block_kind;
	} cmd_t;

	typedef struct packed {
		logic                is_solid;
		logic [FACES-1:0]    face_mask;
		logic                is_interior;
		logic [OFFSET_W-1:0] base_vertex;
		logic [COUNT_W-1:0]  solid_count;
		logic [SUM_W-1:0]    sum_x;
		logic [SUM_W-1:0]    sum_y;
		logic [SUM_W-1:0]    sum_z;
	} rsp_t;

	// Back-end status seen by the front end
	typedef struct packed {
		logic pop;
		logic clearing;
	} back_stat_t;

	typedef struct packed {
		logic [PROBE_W-1:0] x;
		logic [PROBE_W-1:0] y;
		logic [PROBE_W-1:0] z;
		logic               under;
	} probe_t;

	// Coordinates of one probe; under flags a step below zero
	function automatic probe_t probe_coord(input logic [PROBE_CNT_W-1:0] idx,
			input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
			input logic [POS_W-1:0] z);
		probe_t p;
		p.x = {1'b0, x};
		p.y = {1'b0, y};
		p.z = {1'b0, z};
		p.under = 1'b0;
		case (idx)
			PROBE_YP: p.y = p.y + 1'b1;
			PROBE_YN: begin
				p.under = (y == '0);
				p.y = p.y - 1'b1;
			end
			PROBE_ZP: p.z = p.z + 1'b1;
			PROBE_ZN: begin
				p.under = (z == '0);
				p.z = p.z - 1'b1;
			end
			PROBE_XP: p.x = p.x + 1'b1;
			PROBE_XN: begin
				p.under = (x == '0);
				p.x = p.x - 1'b1;
			end
			default: ;
		endcase
		return p;
	endfunction

endpackage

@@ rtl/vfcm_if.sv @@
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps

interface vfcm_cmd_if;
	import vfcm_pkg::*;
	logic valid;
	logic ready;
	cmd_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface vfcm_rsp_if;
	import vfcm_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/vfcm_front.sv @@
// Front end: accepts commands, drops unused opcodes, queues the rest.
`timescale 1ns / 1ps

module vfcm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	vfcm_cmd_if.sink             cmd,
	input  vfcm_pkg::back_stat_t stat,
	output logic                 q_valid,
	output vfcm_pkg::cmd_t       q_item
);
	import vfcm_pkg::*;

	cmd_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic                accept;
	logic                push;
	logic                pop;

	assign cmd.ready = !stat.clearing && (count_q != QUEUE_CW'(QUEUE_DEPTH));
	assign accept = cmd.valid && cmd.ready;
	// opcode 3 is taken and dropped here
	assign push = accept && (cmd.data.operation == OP_WRITE ||
		cmd.data.operation == OP_MESH || cmd.data.operation == OP_START);
	assign q_valid = (count_q != '0);
	assign q_item = entry_q[rd_ptr_q];
	assign pop = stat.pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/vfcm_back.sv @@
// Back end: voxel memory, probe sequencer, running totals, result register.
`timescale 1ns / 1ps

module vfcm_back #(
	parameter int CUBE_EDGE = vfcm_pkg::CUBE_EDGE_DEF,
	parameter int KIND_BITS = vfcm_pkg::KIND_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  vfcm_pkg::cmd_t       q_item,
	output vfcm_pkg::back_stat_t stat,
	vfcm_rsp_if.source           rsp
);
	import vfcm_pkg::*;

	localparam int DEPTH = CUBE_EDGE * CUBE_EDGE * CUBE_EDGE;
	localparam int AW    = $clog2(DEPTH);
	localparam int KW    = KIND_BITS;
	localparam int OFS1  = OFFSET_W + 1;
	localparam int CNT1  = COUNT_W + 1;
	localparam int SUM1  = SUM_W + 1;

	logic [KW-1:0] mem [DEPTH];
	logic [KW-1:0] rd_data_q;

	state_t state_q, state_d;
	logic [AW-1:0]          clr_addr_q;
	logic [PROBE_CNT_W-1:0] probe_q;
	logic [POS_W-1:0]       px_q, py_q, pz_q;
	logic                   prev_in_q;
	logic [NUM_PROBES-1:0]  one_q, zero_q;

	logic [OFFSET_W-1:0] vtx_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]    sx_q, sy_q, sz_q;

	logic out_valid_q;
	rsp_t out_q;

	// control
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [KW-1:0] mem_wdata;
	logic          pop;
	logic          clr_totals;
	logic          collect;
	logic          load_res;

	function automatic logic [AW-1:0] lin_addr(input logic [PROBE_W-1:0] x,
			input logic [PROBE_W-1:0] y, input logic [PROBE_W-1:0] z);
		return (AW'(x) * AW'(CUBE_EDGE) + AW'(y)) * AW'(CUBE_EDGE) + AW'(z);
	endfunction

	// probe address
	probe_t        pc;
	logic          probe_in;
	logic [AW-1:0] probe_addr;
	assign pc = probe_coord(probe_q, px_q, py_q, pz_q);
	assign probe_in = !pc.under && (int'(pc.x) < CUBE_EDGE) &&
		(int'(pc.y) < CUBE_EDGE) && (int'(pc.z) < CUBE_EDGE);
	assign probe_addr = lin_addr(pc.x, pc.y, pc.z);

	// write address
	logic          wr_in;
	logic [AW-1:0] wr_addr;
	assign wr_in = (int'(q_item.pos_x) < CUBE_EDGE) && (int'(q_item.pos_y) < CUBE_EDGE) &&
		(int'(q_item.pos_z) < CUBE_EDGE);
	assign wr_addr = lin_addr({1'b0, q_item.pos_x}, {1'b0, q_item.pos_y},
		{1'b0, q_item.pos_z});

	// probe classification from the registered read
	logic is_one, is_zero;
	assign is_one = prev_in_q && (rd_data_q == KW'(SOLID_ID));
	assign is_zero = !prev_in_q || (rd_data_q == '0);

	// result math
	logic                  solid;
	logic [FACES-1:0]      mask;
	logic                  interior;
	logic [FACE_CNT_W-1:0] faces;
	logic [OFS1-1:0]       vtx_sum;
	logic [CNT1-1:0]       cnt_sum;
	logic [SUM1-1:0]       sx_sum, sy_sum, sz_sum;
	logic [OFFSET_W-1:0]   vtx_new;
	logic [COUNT_W-1:0]    cnt_new;
	logic [SUM_W-1:0]      sx_new, sy_new, sz_new;

	assign solid = one_q[PROBE_CTR];
	assign mask = solid ? zero_q[NUM_PROBES-1:1] : '0;
	assign interior = solid && (&one_q[NUM_PROBES-1:1]);
	assign faces = FACE_CNT_W'($countones(mask));
	assign vtx_sum = {1'b0, vtx_q} + OFS1'(faces) * OFS1'(VERTS_PER_FACE);
	assign cnt_sum = {1'b0, cnt_q} + 1'b1;
	assign sx_sum = {1'b0, sx_q} + SUM1'(px_q);
	assign sy_sum = {1'b0, sy_q} + SUM1'(py_q);
	assign sz_sum = {1'b0, sz_q} + SUM1'(pz_q);
	assign vtx_new = vtx_sum[OFFSET_W] ? '1 : vtx_sum[OFFSET_W-1:0];
	assign cnt_new = cnt_sum[COUNT_W] ? '1 : cnt_sum[COUNT_W-1:0];
	assign sx_new = sx_sum[SUM_W] ? '1 : sx_sum[SUM_W-1:0];
	assign sy_new = sy_sum[SUM_W] ? '1 : sy_sum[SUM_W-1:0];
	assign sz_new = sz_sum[SUM_W] ? '1 : sz_sum[SUM_W-1:0];

	// outputs of the sequencer
	always_comb begin
		mem_we = 1'b0;
		mem_addr = probe_addr;
		mem_wdata = KW'(SOLID_ID);
		pop = 1'b0;
		clr_totals = 1'b0;
		collect = 1'b0;
		load_res = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_addr = clr_addr_q;
			end
			ST_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					case (q_item.operation)
						OP_WRITE: begin
							mem_we = wr_in;
							mem_addr = wr_addr;
							mem_wdata = KW'(q_item.block_kind);
						end
						OP_START: clr_totals = 1'b1;
						default: ;
					endcase
				end
			end
			ST_MESH: collect = (probe_q != PROBE_CTR);
			ST_FINISH: load_res = !out_valid_q || rsp.ready;
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_addr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: if (q_valid && q_item.operation == OP_MESH) state_d = ST_MESH;
			ST_MESH: if (probe_q == PROBE_DONE) state_d = ST_FINISH;
			ST_FINISH: if (load_res) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign stat.pop = pop;
	assign stat.clearing = (state_q == ST_CLEAR);

	// single-port voxel memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop && q_item.operation == OP_MESH) begin
			px_q <= q_item.pos_x;
			py_q <= q_item.pos_y;
			pz_q <= q_item.pos_z;
		end
		prev_in_q <= probe_in;
		if (collect) begin
			one_q <= {is_one, one_q[NUM_PROBES-1:1]};
			zero_q <= {is_zero, zero_q[NUM_PROBES-1:1]};
		end
		if (load_res) begin
			out_q.is_solid <= solid;
			out_q.face_mask <= mask;
			out_q.is_interior <= interior;
			out_q.base_vertex <= vtx_q;
			out_q.solid_count <= solid ? cnt_new : cnt_q;
			out_q.sum_x <= solid ? sx_new : sx_q;
			out_q.sum_y <= solid ? sy_new : sy_q;
			out_q.sum_z <= solid ? sz_new : sz_q;
		end
	end

	// control state and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_addr_q <= '0;
			probe_q <= PROBE_CTR;
			vtx_q <= '0;
			cnt_q <= '0;
			sx_q <= '0;
			sy_q <= '0;
			sz_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (state_q == ST_MESH) begin
				probe_q <= probe_q + 1'b1;
			end else begin
				probe_q <= PROBE_CTR;
			end
			if (clr_totals) begin
				vtx_q <= '0;
				cnt_q <= '0;
				sx_q <= '0;
				sy_q <= '0;
				sz_q <= '0;
			end else if (load_res && solid) begin
				vtx_q <= vtx_new;
				cnt_q <= cnt_new;
				sx_q <= sx_new;
				sy_q <= sy_new;
				sz_q <= sz_new;
			end
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data = out_q;

	a_clear_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !pop)
		else $error("command popped during memory clear");

	a_mem_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_IDLE))
		else $error("memory write during a mesh query");

	a_vtx_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(vtx_q[1:0] == 2'b00) || (&vtx_q))
		else $error("vertex offset not a whole number of quads");

	a_empty_sums: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (sx_q == '0 && sy_q == '0 && sz_q == '0))
		else $error("coordinate sums nonzero with no solid voxels");

	a_finish_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && $past(state_q) != ST_FINISH) |->
		($past(state_q) == ST_MESH && $past(probe_q) == PROBE_DONE))
		else $error("finish reached before all probes collected");

endmodule

@@ rtl/voxel_face_cull_mesher_unit.sv @@
// Top level of the voxel face cull mesher.
//
//  channel  dir  payload  handshake    transaction
//  cmd      in   cmd_t    valid/ready  write voxel, mesh voxel, start build
//  rsp      out  rsp_t    valid/ready  one result per mesh command
//
// Write and start commands act as the back end pops them; a mesh command runs pop,
// reads of the center and six neighbors from the single-port voxel memory, the
// collect of the last read and finish. After reset the memory is filled with the
// solid id, one entry a cycle, with cmd.ready low until all CUBE_EDGE^3 are set.
// A 2-deep command queue lets the front take commands while the back works;
// a full result register holds the back in its finish step until rsp takes it.
`timescale 1ns / 1ps

module voxel_face_cull_mesher_unit #(
	parameter int CUBE_EDGE = vfcm_pkg::CUBE_EDGE_DEF,
	parameter int KIND_BITS = vfcm_pkg::KIND_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	vfcm_cmd_if.sink    cmd,
	vfcm_rsp_if.source  rsp
);
	import vfcm_pkg::*;

	// queue head handed to the back end
	logic       q_valid;
	cmd_t       q_item;
	// back end pops the head and reports its memory clear
	back_stat_t stat;

	// Front: takes transactions, drops unused opcodes, buffers the rest in order
	vfcm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.q_valid(q_valid),
		.q_item (q_item)
	);

	// Back: voxel store, neighbor probing, running totals, result register
	vfcm_back #(
		.CUBE_EDGE(CUBE_EDGE),
		.KIND_BITS(KIND_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_item (q_item),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the voxel face cull mesher unit.
`timescale 1ns / 1ps

module tb;
	import vfcm_pkg::*;

	// Run setup
	localparam int CLK_PERIOD   = 10;
	localparam int IDLE_PCT     = 38;        // chance of an idle cycle per side
	localparam int RANDOM_ITEMS = 620;       // counted random commands (op 3 excluded)
	localparam int SAT_MESHES   = 40;        // repeated meshes of the isolated corner
	localparam int HOLD_CYCLES  = 400;       // long rsp back-pressure stretch
	localparam int DRAIN_CYCLES = 40;        // extra wait after the results drain
	localparam int MAX_REPORTS  = 10;
	localparam int TIMEOUT_NS   = 2_000_000;

	// Block geometry and saturation limits
	localparam int EDGE_LEN    = CUBE_EDGE_DEF;
	localparam int STORE_DEPTH = EDGE_LEN * EDGE_LEN * EDGE_LEN;
	localparam int OFFSET_MAX  = (1 << OFFSET_W) - 1;
	localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
	localparam int SUM_MAX     = (1 << SUM_W) - 1;
	localparam int EDGE_TOP    = EDGE_LEN - 1;

	// Opcode the block must swallow without a result
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// Neighbor step per face bit: +y, -y, +z, -z, +x, -x
	localparam int FACE_DX [FACES] = '{0, 0, 0, 0, 1, -1};
	localparam int FACE_DY [FACES] = '{1, -1, 0, 0, 0, 0};
	localparam int FACE_DZ [FACES] = '{0, 0, 1, -1, 0, 0};

	// Mirror of the voxel store and running build totals; holds the queue of
	// results still owed by the block and checks each one as it leaves.
	class face_mesh_board;
		logic [IN_KIND_W-1:0] voxels [STORE_DEPTH];
		int vert_offset, solid_total, x_total, y_total, z_total;
		rsp_t pending_meshes[$];
		int errors, reported, n_checked;
		int n_write, n_mesh, n_start, n_unused, n_solid, n_interior;
		int hit_offset_max, hit_count_max, hit_sum_max;

		function new();
			foreach (voxels[i]) voxels[i] = IN_KIND_W'(SOLID_ID);
		endfunction

		function logic [IN_KIND_W-1:0] kind_at(int x, int y, int z);
			// outside the cube reads as empty
			if (x < 0 || x >= EDGE_LEN || y < 0 || y >= EDGE_LEN || z < 0 || z >= EDGE_LEN)
				return '0;
			return voxels[(x * EDGE_LEN + y) * EDGE_LEN + z];
		endfunction

		function int sat_add(int a, int b, int lim);
			return (a + b > lim) ? lim : a + b;
		endfunction

		function void report(string msg);
			errors++;
			if (reported < MAX_REPORTS) begin
				reported++;
				$display("%0t: %s", $time, msg);
			end
		endfunction

		function void take_command(cmd_t c);
			int x, y, z, faces;
			logic [IN_KIND_W-1:0] nb;
			rsp_t r;
			x = int'(c.pos_x);
			y = int'(c.pos_y);
			z = int'(c.pos_z);
			case (c.operation)
				OP_WRITE: begin
					n_write++;
					voxels[(x * EDGE_LEN + y) * EDGE_LEN + z] = c.block_kind;
				end
				OP_START: begin
					n_start++;
					vert_offset = 0;
					solid_total = 0;
					x_total = 0;
					y_total = 0;
					z_total = 0;
				end
				OP_MESH: begin
					n_mesh++;
					r = '0;
					faces = 0;
					r.base_vertex = OFFSET_W'(vert_offset);
					r.is_solid = (kind_at(x, y, z) == IN_KIND_W'(SOLID_ID));
					if (r.is_solid) begin
						n_solid++;
						r.is_interior = 1'b1;
						for (int k = 0; k < FACES; k++) begin
							nb = kind_at(x + FACE_DX[k], y + FACE_DY[k], z + FACE_DZ[k]);
							// any id other than solid spoils interior; only empty exposes
							if (nb != IN_KIND_W'(SOLID_ID))
								r.is_interior = 1'b0;
							if (nb == '0) begin
								r.face_mask[k] = 1'b1;
								faces++;
							end
						end
						if (r.is_interior)
							n_interior++;
						vert_offset = sat_add(vert_offset, faces * VERTS_PER_FACE, OFFSET_MAX);
						solid_total = sat_add(solid_total, 1, COUNT_MAX);
						x_total = sat_add(x_total, x, SUM_MAX);
						y_total = sat_add(y_total, y, SUM_MAX);
						z_total = sat_add(z_total, z, SUM_MAX);
						if (vert_offset == OFFSET_MAX)
							hit_offset_max++;
						if (solid_total == COUNT_MAX)
							hit_count_max++;
						if (x_total == SUM_MAX && y_total == SUM_MAX && z_total == SUM_MAX)
							hit_sum_max++;
					end
					r.solid_count = COUNT_W'(solid_total);
					r.sum_x = SUM_W'(x_total);
					r.sum_y = SUM_W'(y_total);
					r.sum_z = SUM_W'(z_total);
					pending_meshes.insert(pending_meshes.size(), r);
				end
				default: n_unused++;
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want)
				report($sformatf("result %0d %s: expected %0d, got %0d",
					n_checked, name, want, got));
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (pending_meshes.size() == 0) begin
				report("result transaction with no mesh command outstanding");
				return;
			end
			want = pending_meshes.pop_front();
			compare_field("is_solid", 32'(want.is_solid), 32'(got.is_solid));
			compare_field("face_mask", 32'(want.face_mask), 32'(got.face_mask));
			compare_field("is_interior", 32'(want.is_interior), 32'(got.is_interior));
			compare_field("base_vertex", 32'(want.base_vertex), 32'(got.base_vertex));
			compare_field("solid_count", 32'(want.solid_count), 32'(got.solid_count));
			compare_field("sum_x", 32'(want.sum_x), 32'(got.sum_x));
			compare_field("sum_y", 32'(want.sum_y), 32'(got.sum_y));
			compare_field("sum_z", 32'(want.sum_z), 32'(got.sum_z));
			n_checked++;
		endfunction

		function void close_out();
			if (pending_meshes.size() != 0)
				report($sformatf("%0d mesh results never arrived", pending_meshes.size()));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   steady  = 1'b0;   // both sides stop idling while set
	bit   hold_go = 1'b0;   // asks the rsp side for its long hold-off

	face_mesh_board board;

	vfcm_cmd_if cmd_ch ();
	vfcm_rsp_if rsp_ch ();

	voxel_face_cull_mesher_unit u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Coordinates lean to the faces of the cube so that neighbors collide often
	function automatic int pick_coord();
		case ($urandom_range(3))
			0, 1: return $urandom_range(3);
			2: return $urandom_range(EDGE_TOP, EDGE_TOP - 3);
			default: return $urandom_range(EDGE_TOP);
		endcase
	endfunction

	// Mostly empty or solid, now and then any other id
	function automatic int pick_kind();
		case ($urandom_range(4))
			0, 1: return 0;
			2, 3: return SOLID_ID;
			default: return $urandom_range(255);
		endcase
	endfunction

	// Offer one command transaction, with a random idle gap ahead of it
	task automatic push_cmd(input logic [OP_W-1:0] op, input int x, input int y,
			input int z, input int kind);
		cmd_t c;
		c.operation  = op;
		c.pos_x      = POS_W'(x);
		c.pos_y      = POS_W'(y);
		c.pos_z      = POS_W'(z);
		c.block_kind = IN_KIND_W'(kind);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			cmd_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= c;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		board.take_command(c);
	endtask

	// Result side: check each accepted transaction, then pick next ready.
	// The long hold-off is counted here so the sender keeps pushing meanwhile
	// and the command queue backs up into cmd.ready.
	initial begin
		int hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				board.check_result(rsp_ch.data);
			if (hold_go && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int counted, roll;
		board = new();
		arst_n       <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.data  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: corners, interior, odd ids, non-solid queries, opcode 3.
		// The block clears its memory first, with cmd.ready low.
		push_cmd(OP_MESH, 0, 0, 0, 8'hFF);
		push_cmd(OP_MESH, EDGE_TOP, EDGE_TOP, EDGE_TOP, 0);
		push_cmd(OP_MESH, 7, 7, 7, 0);                 // fully buried voxel
		push_cmd(OP_WRITE, 7, 8, 7, 0);                // open its +y face
		push_cmd(OP_WRITE, 7, 6, 7, 2);                // -y holds a foreign id
		push_cmd(OP_MESH, 7, 7, 7, 0);
		push_cmd(OP_MESH, 7, 6, 7, 0);                 // foreign id is not solid
		push_cmd(OP_WRITE, 9, 9, 9, 8'hFF);
		push_cmd(OP_MESH, 9, 9, 9, 0);
		push_cmd(OP_MESH, 8, 9, 9, 0);                 // +x neighbor foreign
		push_cmd(OP_WRITE, 7, 7, 7, 0);
		push_cmd(OP_MESH, 7, 7, 7, 0);                 // empty voxel query
		push_cmd(OP_UNUSED, 5, 5, 5, 0);               // must not write
		push_cmd(OP_MESH, 5, 5, 5, 0);
		push_cmd(OP_START, EDGE_TOP, EDGE_TOP, EDGE_TOP, 8'hFF);
		push_cmd(OP_MESH, 0, EDGE_TOP, 0, 0);
		push_cmd(OP_MESH, EDGE_TOP, 0, EDGE_TOP, 0);
		push_cmd(OP_WRITE, 7, 8, 7, SOLID_ID);
		push_cmd(OP_WRITE, 7, 6, 7, SOLID_ID);
		push_cmd(OP_WRITE, 7, 7, 7, SOLID_ID);
		push_cmd(OP_WRITE, 9, 9, 9, SOLID_ID);

		// Isolate the top corner so every mesh adds 24 vertices, then mesh it
		// a number of times back to back.
		push_cmd(OP_WRITE, EDGE_TOP - 1, EDGE_TOP, EDGE_TOP, 0);
		push_cmd(OP_WRITE, EDGE_TOP, EDGE_TOP - 1, EDGE_TOP, 0);
		push_cmd(OP_WRITE, EDGE_TOP, EDGE_TOP, EDGE_TOP - 1, 0);
		push_cmd(OP_START, 0, 0, 0, 0);
		for (int i = 0; i < SAT_MESHES; i++)
			push_cmd(OP_MESH, EDGE_TOP, EDGE_TOP, EDGE_TOP, $urandom_range(255));
		push_cmd(OP_START, 0, 0, 0, 0);

		// Random: writes and meshes around the cube faces, the odd build start,
		// stray opcode 3 on top (not counted)
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if (counted == 100)
				hold_go = 1'b1;
			steady = (counted >= 300 && counted < 450);
			roll = $urandom_range(99);
			if (roll < 45)
				push_cmd(OP_WRITE, pick_coord(), pick_coord(), pick_coord(), pick_kind());
			else if (roll < 90)
				push_cmd(OP_MESH, pick_coord(), pick_coord(), pick_coord(),
					$urandom_range(255));
			else if (roll < 95)
				push_cmd(OP_START, $urandom_range(EDGE_TOP), $urandom_range(EDGE_TOP),
					$urandom_range(EDGE_TOP), $urandom_range(255));
			else
				push_cmd(OP_UNUSED, $urandom_range(EDGE_TOP), $urandom_range(EDGE_TOP),
					$urandom_range(EDGE_TOP), $urandom_range(255));
			if (roll < 95)
				counted++;
		end
		steady = 1'b0;
		cmd_ch.valid <= 1'b0;

		// Drain, then wait on to catch stray results
		while (board.pending_meshes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		board.close_out();

		$display("Run covered %0d writes, %0d meshes, %0d build starts, %0d opcode-3 commands;",
			board.n_write, board.n_mesh, board.n_start, board.n_unused);
		$display("%0d results checked (%0d solid, %0d interior), saturated meshes: %0d/%0d/%0d.",
			board.n_checked, board.n_solid, board.n_interior, board.hit_offset_max,
			board.hit_count_max, board.hit_sum_max);
		if (board.errors == 0)
			$display("[voxel_face_cull_mesher_unit] OK");
		else
			$display("[voxel_face_cull_mesher_unit] ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d mesh results outstanding", board.pending_meshes.size());
		$display("[voxel_face_cull_mesher_unit] ERROR");
		$finish;
	end

endmodule

@@ voxel_face_cull_mesher_unit.f @@
rtl/vfcm_pkg.sv
rtl/vfcm_if.sv
rtl/vfcm_front.sv
rtl/vfcm_back.sv
rtl/voxel_face_cull_mesher_unit.sv
verif/tb.sv
